// ----- rtl/core/gpioei_pkg.sv -----
package gpioei_pkg;

   localparam int PIN_COUNT = 32;
   localparam logic [31:0] PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

   localparam int CTRL_ECLK_BIT = 0;
   localparam int CTRL_NEC_BIT  = 1;
   localparam int CTRL_INTE_BIT = 2;
   localparam int CTRL_INTS_BIT = 3;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_PAD   = 3'd2,
      OP_AUX   = 3'd3,
      OP_TICK  = 3'd4,
      OP_ECLK  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      REG_IN    = 3'd0,
      REG_OUT   = 3'd1,
      REG_OE    = 3'd2,
      REG_INTE  = 3'd3,
      REG_PTRIG = 3'd4,
      REG_AUX   = 3'd5,
      REG_CTRL  = 3'd6,
      REG_INTS  = 3'd7
   } reg_index_type;

   typedef logic [7:0][31:0] bank_type;

   typedef struct packed {
      logic changed;
      logic raised;
   } dclk_flags_type;

endpackage

// ----- rtl/core/gpioei_devclk.sv -----
module gpioei_devclk
   import gpioei_pkg::*;
(
   input  bank_type       pend,
   input  bank_type       vis,
   input  logic [31:0]    aux_levels,
   output bank_type       pend_next,
   output dclk_flags_type flags
);

   logic [31:0] in_masked;
   logic [31:0] out_muxed;
   logic [31:0] diff;
   logic [31:0] rose;
   logic [31:0] fell;
   logic [31:0] hit;
   logic        raised;

   always_comb begin
      in_masked = pend[REG_IN] & ~pend[REG_OE] & PIN_MASK;
      out_muxed = ((pend[REG_OUT] & ~pend[REG_AUX]) | (aux_levels & pend[REG_AUX]))
                  & pend[REG_OE] & PIN_MASK;

      diff = in_masked ^ vis[REG_IN];
      rose = diff & in_masked;
      fell = diff & vis[REG_IN];
      hit  = ((pend[REG_PTRIG] & rose) | (~pend[REG_PTRIG] & fell))
             & pend[REG_INTE] & PIN_MASK;
      raised = pend[REG_CTRL][CTRL_INTE_BIT] && (hit != '0);

      pend_next = pend;
      pend_next[REG_IN]  = in_masked;
      pend_next[REG_OUT] = out_muxed;
      if (raised) begin
         pend_next[REG_CTRL][CTRL_INTS_BIT] = 1'b1;
         pend_next[REG_INTS] = pend[REG_INTS] | hit;
      end

      flags.changed = (out_muxed != vis[REG_OUT]);
      flags.raised  = raised;
   end

endmodule

// ----- rtl/core/gpio_controller_edge_interrupts_unit.sv -----
// A request waits in the input register and moves on to the result register
// when the result register is free or being drained.
// Throughput: one request per cycle unless the result register stalls; the
// register bank update for an item finishes in the same cycle its result is registered.
// Reset: synchronous, clears both register banks, the aux levels, the stored
// external clock level and both pipeline valid flags.
module gpio_controller_edge_interrupts_unit
   import gpioei_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_in[31:0]
   input  logic [5:0]  req_tuser,   // opcode[2:0], reg_index[5:3]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], pad_out[63:32], out_changed[64], irq_raise[65],
   // irq_clear[66], zero fill [71:67]
   output logic [71:0] rsp_tdata
);

   // Input register.
   logic        in_vld_ff;
   logic        in_vld_in;
   logic [31:0] in_data_ff;
   logic [5:0]  in_user_ff;

   // Result register.
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   logic [71:0] rsp_data_ff;
   logic [71:0] rsp_data_in;

   // Controller state.
   bank_type    vis_ff;
   bank_type    vis_in;
   bank_type    pend_ff;
   bank_type    pend_in;
   logic [31:0] aux_ff;
   logic [31:0] aux_in;
   logic        eclk_lvl_ff;
   logic        eclk_lvl_in;

   logic           advance;
   opcode_type     op;
   reg_index_type  idx;
   logic [31:0]    rd;
   logic           do_clk;
   logic           cleared;
   logic           lvl;
   bank_type       dc_pend;
   dclk_flags_type dc_flags;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign op  = opcode_type'(in_user_ff[2:0]);
   assign idx = reg_index_type'(in_user_ff[5:3]);

   gpioei_devclk u_devclk (
      .pend       (pend_ff),
      .vis        (vis_ff),
      .aux_levels (aux_ff),
      .pend_next  (dc_pend),
      .flags      (dc_flags)
   );

   always_comb begin
      pend_in     = pend_ff;
      vis_in      = vis_ff;
      aux_in      = aux_ff;
      eclk_lvl_in = eclk_lvl_ff;
      rd          = '0;
      do_clk      = 1'b0;
      cleared     = 1'b0;
      lvl         = in_data_ff[0];

      case (op)
         OP_READ: begin
            if (idx == REG_IN) begin
               rd = vis_ff[REG_IN] | vis_ff[REG_OUT];
            end else begin
               rd = vis_ff[idx];
            end
         end
         OP_WRITE: begin
            if (idx == REG_CTRL) begin
               pend_in[REG_CTRL] = in_data_ff;
            end else if (idx != REG_IN) begin
               cleared = (idx == REG_INTS) && (pend_ff[REG_INTS] != '0)
                         && ((in_data_ff & PIN_MASK) == '0);
               pend_in[idx] = in_data_ff & PIN_MASK;
            end
         end
         OP_PAD: begin
            pend_in[REG_IN] = in_data_ff & PIN_MASK;
         end
         OP_AUX: begin
            aux_in = in_data_ff & PIN_MASK;
         end
         OP_TICK: begin
            do_clk = !vis_ff[REG_CTRL][CTRL_ECLK_BIT];
         end
         OP_ECLK: begin
            // The stored level tracks every level event, clocked or not.
            eclk_lvl_in = lvl;
            do_clk = vis_ff[REG_CTRL][CTRL_ECLK_BIT] && (lvl != eclk_lvl_ff)
                     && (lvl != vis_ff[REG_CTRL][CTRL_NEC_BIT]);
         end
         default: begin
         end
      endcase

      if (do_clk) begin
         pend_in = dc_pend;
         vis_in  = dc_pend;
      end

      rsp_data_in = {5'b0,
                     cleared,
                     do_clk && dc_flags.raised,
                     do_clk && dc_flags.changed,
                     vis_in[REG_OUT] & PIN_MASK,
                     rd};

      in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
      rsp_vld_in = advance ? 1'b1 : (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         vis_ff      <= '0;
         pend_ff     <= '0;
         aux_ff      <= '0;
         eclk_lvl_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            vis_ff      <= vis_in;
            pend_ff     <= pend_in;
            aux_ff      <= aux_in;
            eclk_lvl_ff <= eclk_lvl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The pin value in a waiting result always matches the visible output bank.
   a_pad_out_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_data_ff[63:32] == (vis_ff[REG_OUT] & PIN_MASK)))
      else $error("pad_out in result differs from visible OUT");

   // A bus read never alters the visible bank.
   a_read_no_side_effect: assert property (@(posedge clock) disable iff (reset)
      (advance && op == OP_READ) |=> $stable(vis_ff))
      else $error("bus read changed visible registers");

   // A raised interrupt leaves the interrupt-seen bit set in visible CTRL.
   a_raise_sets_ints: assert property (@(posedge clock) disable iff (reset)
      (advance && do_clk && dc_flags.raised) |=> vis_ff[REG_CTRL][CTRL_INTS_BIT])
      else $error("interrupt raised without CTRL.INTS");

   // A clearing write leaves the pending status at zero.
   a_clear_zeroes_status: assert property (@(posedge clock) disable iff (reset)
      (advance && cleared) |=> (pend_ff[REG_INTS] == '0))
      else $error("status clear left pending INTS nonzero");

   // A stalled result register holds the pipeline.
   a_no_advance_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("result overwritten while stalled");

endmodule
